// ----- hw/rtl/cngc_pkg.sv -----
// Shared constants and register codes for the character n-gram frequency counter.
`default_nettype none

package cngc_pkg;

    // Table and gram sizing.
    localparam int TABLE_DEPTH = 256;
    localparam int MAX_GRAM    = 5;
    localparam int COUNT_BITS  = 24;

    // Derived widths.
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int USED_W  = IDX_W + 1;
    localparam int KEY_W   = 8 * MAX_GRAM;
    localparam int LEN_W   = $clog2(MAX_GRAM + 1);
    localparam int ENTRY_W = KEY_W + COUNT_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam logic [0:0] REG_GRAM_LENGTH = 1'b0;

    // Command codes.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_READ = 1'b1;

endpackage

`default_nettype wire

// ----- hw/rtl/cngc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module cngc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/char_ngram_frequency_counter.sv -----
// Top level of the character n-gram frequency counter: window, scan sequencer and table.
//
// Channel   | Handshake            | Payload
// ----------+----------------------+---------------------------------------------------
// command   | start / busy         | i_command, i_char_byte, i_end_of_file, i_read_index
// result    | o_result_strobe      | o_entry_index, o_gram_text, o_gram_count,
//           |                      | o_is_new, o_table_full, o_entry_valid
// config    | APB psel/penable/... | gram_length at byte address 0
//
// An item is taken when start is high and busy is low. A push that does not yet complete
// a gram updates only the window and fill count and gives no result. A push that completes
// a gram scans the table one entry per cycle through the single read port of the table RAM,
// with the compare in the cycle after the read. A hit on entry k ends the scan early.
// A read command fetches its entry through the registered RAM read. Reset is synchronous
// and active low; it clears the window, the fill count, the entry count and gram_length
// (to one). The table RAM is not cleared: only entries below the entry count are ever
// looked at. Each result is presented for exactly one cycle; the receiver cannot stall it.
`default_nettype none

module char_ngram_frequency_counter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Command channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_command,
    input  wire logic [7:0]  i_char_byte,
    input  wire logic        i_end_of_file,
    input  wire logic [7:0]  i_read_index,
    // Result channel
    output logic             o_result_strobe,
    output logic [7:0]       o_entry_index,
    output logic [39:0]      o_gram_text,
    output logic [23:0]      o_gram_count,
    output logic             o_is_new,
    output logic             o_table_full,
    output logic             o_entry_valid,
    // Configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cngc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    logic [1:0]                       r_state, n_state;
    logic [cngc_pkg::KEY_W-1:0]       r_win, n_win;
    logic [cngc_pkg::LEN_W-1:0]       r_fill, n_fill;
    logic [cngc_pkg::USED_W-1:0]      r_used, n_used;
    logic [2:0]                       r_gram_length;
    logic [cngc_pkg::KEY_W-1:0]       r_key, n_key;
    logic [cngc_pkg::USED_W-1:0]      r_addr, n_addr;
    logic [cngc_pkg::IDX_W-1:0]       r_paddr, n_paddr;
    logic                             r_pend, n_pend;
    logic [7:0]                       r_read_index, n_read_index;
    logic                             r_read_ok, n_read_ok;

    // Result registers.
    logic                             r_strobe, n_strobe;
    logic [7:0]                       r_out_index, n_out_index;
    logic [39:0]                      r_out_text, n_out_text;
    logic [23:0]                      r_out_count, n_out_count;
    logic                             r_out_new, n_out_new;
    logic                             r_out_full, n_out_full;
    logic                             r_out_valid, n_out_valid;

    // Table RAM signals.
    logic                             ram_we;
    logic [cngc_pkg::IDX_W-1:0]       ram_waddr;
    logic [cngc_pkg::ENTRY_W-1:0]     ram_wdata;
    logic [cngc_pkg::IDX_W-1:0]       ram_raddr;
    logic [cngc_pkg::ENTRY_W-1:0]     ram_rdata;
    logic [cngc_pkg::KEY_W-1:0]       rd_key;
    logic [cngc_pkg::COUNT_BITS-1:0]  rd_count;
    logic [cngc_pkg::COUNT_BITS-1:0]  inc_count;

    // Push datapath.
    logic [cngc_pkg::LEN_W-1:0]       eff_len;
    logic [cngc_pkg::KEY_W-1:0]       shift_win;
    logic [cngc_pkg::LEN_W-1:0]       fill_inc;
    logic [cngc_pkg::KEY_W-1:0]       new_key;
    logic                             cfg_write;
    logic                             hit;

    cngc_ram #(
        .WIDTH (cngc_pkg::ENTRY_W),
        .DEPTH (cngc_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_key   = ram_rdata[cngc_pkg::ENTRY_W-1:cngc_pkg::COUNT_BITS];
    assign rd_count = ram_rdata[cngc_pkg::COUNT_BITS-1:0];
    // Counts saturate at the all-ones value.
    assign inc_count = (rd_count == cngc_pkg::COUNT_MAX) ? rd_count
                                                         : rd_count + 1'b1;
    assign hit = r_pend && (rd_key == r_key);

    // A gram length of zero behaves as one; anything above the window size is clamped.
    always_comb begin
        if (r_gram_length == 3'd0) begin
            eff_len = cngc_pkg::LEN_W'(1);
        end else if (32'(r_gram_length) > cngc_pkg::MAX_GRAM) begin
            eff_len = cngc_pkg::LEN_W'(cngc_pkg::MAX_GRAM);
        end else begin
            eff_len = cngc_pkg::LEN_W'(r_gram_length);
        end
    end

    // The newest byte enters the low end of the window.
    assign shift_win = (r_win << 8) | cngc_pkg::KEY_W'(i_char_byte);
    assign fill_inc  = (32'(r_fill) < cngc_pkg::MAX_GRAM) ? r_fill + 1'b1 : r_fill;

    // The key puts the oldest of the last eff_len bytes in its lowest byte.
    always_comb begin
        new_key = '0;
        for (int i = 0; i < cngc_pkg::MAX_GRAM; i++) begin
            for (int j = 0; j < cngc_pkg::MAX_GRAM; j++) begin
                if (32'(eff_len) == i + j + 1) begin
                    new_key[8*i +: 8] = shift_win[8*j +: 8];
                end
            end
        end
    end

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_win        = r_win;
        n_fill       = r_fill;
        n_used       = r_used;
        n_key        = r_key;
        n_addr       = r_addr;
        n_paddr      = r_paddr;
        n_pend       = r_pend;
        n_read_index = r_read_index;
        n_read_ok    = r_read_ok;
        n_strobe     = 1'b0;
        n_out_index  = r_out_index;
        n_out_text   = r_out_text;
        n_out_count  = r_out_count;
        n_out_new    = r_out_new;
        n_out_full   = r_out_full;
        n_out_valid  = r_out_valid;
        ram_we       = 1'b0;
        ram_waddr    = r_paddr;
        ram_wdata    = {r_key, inc_count};
        ram_raddr    = r_addr[cngc_pkg::IDX_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_command == cngc_pkg::CMD_READ) begin
                        // Fetch the entry; the bound check is settled now.
                        ram_raddr    = cngc_pkg::IDX_W'(i_read_index);
                        n_read_index = i_read_index;
                        n_read_ok    = 32'(i_read_index) < 32'(r_used);
                        n_state      = ST_READ;
                    end else begin
                        if (i_end_of_file) begin
                            n_win  = '0;
                            n_fill = '0;
                        end else begin
                            n_win  = shift_win;
                            n_fill = fill_inc;
                        end
                        // Only a full window produces a gram to look up.
                        if (32'(fill_inc) >= 32'(eff_len)) begin
                            n_key   = new_key;
                            n_addr  = '0;
                            n_pend  = 1'b0;
                            n_state = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN: begin
                if (hit) begin
                    ram_we      = 1'b1;
                    ram_waddr   = r_paddr;
                    ram_wdata   = {r_key, inc_count};
                    n_strobe    = 1'b1;
                    n_out_index = 8'(r_paddr);
                    n_out_text  = 40'(r_key);
                    n_out_count = 24'(inc_count);
                    n_out_new   = 1'b0;
                    n_out_full  = 1'b0;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end else if (r_addr >= r_used) begin
                    // Every entry in use was compared without a match.
                    n_strobe   = 1'b1;
                    n_out_text = 40'(r_key);
                    n_out_new  = 1'b0;
                    n_out_full = 1'b1;
                    n_out_valid = 1'b0;
                    n_out_index = 8'd0;
                    n_out_count = 24'd0;
                    if (32'(r_used) < cngc_pkg::TABLE_DEPTH) begin
                        ram_we      = 1'b1;
                        ram_waddr   = r_used[cngc_pkg::IDX_W-1:0];
                        ram_wdata   = {r_key, cngc_pkg::COUNT_BITS'(1)};
                        n_used      = r_used + 1'b1;
                        n_out_index = 8'(r_used);
                        n_out_count = 24'(1);
                        n_out_new   = 1'b1;
                        n_out_full  = 1'b0;
                        n_out_valid = 1'b1;
                    end
                    n_state = ST_IDLE;
                end else begin
                    // Issue the next read; its data is compared next cycle.
                    n_paddr = r_addr[cngc_pkg::IDX_W-1:0];
                    n_addr  = r_addr + 1'b1;
                    n_pend  = 1'b1;
                end
            end

            ST_READ: begin
                n_strobe    = 1'b1;
                n_out_index = r_read_index;
                n_out_new   = 1'b0;
                n_out_full  = 1'b0;
                n_out_valid = r_read_ok;
                if (r_read_ok) begin
                    n_out_text  = 40'(rd_key);
                    n_out_count = 24'(rd_count);
                end else begin
                    n_out_text  = 40'd0;
                    n_out_count = 24'd0;
                end
                n_state = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_win         <= '0;
            r_fill        <= '0;
            r_used        <= '0;
            r_gram_length <= 3'd1;
            r_pend        <= 1'b0;
            r_strobe      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_win    <= n_win;
            r_fill   <= n_fill;
            r_used   <= n_used;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
            if (cfg_write && (paddr[2:2] == cngc_pkg::REG_GRAM_LENGTH)) begin
                r_gram_length <= pwdata[2:0];
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_addr       <= n_addr;
        r_paddr      <= n_paddr;
        r_read_index <= n_read_index;
        r_read_ok    <= n_read_ok;
        r_out_index  <= n_out_index;
        r_out_text   <= n_out_text;
        r_out_count  <= n_out_count;
        r_out_new    <= n_out_new;
        r_out_full   <= n_out_full;
        r_out_valid  <= n_out_valid;
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_entry_index   = r_out_index;
    assign o_gram_text     = r_out_text;
    assign o_gram_count    = r_out_count;
    assign o_is_new        = r_out_new;
    assign o_table_full    = r_out_full;
    assign o_entry_valid   = r_out_valid;

    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == cngc_pkg::REG_GRAM_LENGTH) ? {29'd0, r_gram_length}
                                                              : 32'd0;

endmodule

`default_nettype wire
